// File: hdl/sdce_pkg.sv
// Shared types, widths and the Q16.16 saturation helper of the DOF expander.
package sdce_pkg;

	localparam int DOF_W  = 13;
	localparam int COL_W  = 12;
	localparam int POS_W  = 14;
	localparam int FREE_W = 12;
	localparam int VAL_W  = 32;
	localparam int PROD_W = 2 * VAL_W;

	// request codes of an input item
	typedef enum logic [1:0] {
		REQ_LOAD_OFFSET = 2'd0,
		REQ_LOAD_ENTRY  = 2'd1,
		REQ_NONZERO     = 2'd2,
		REQ_RHS         = 2'd3
	} req_t;

	// one expansion table entry
	typedef struct packed {
		logic [FREE_W-1:0]       free;
		logic signed [VAL_W-1:0] w;
	} ent_t;

	// routing and flags that travel with a product
	typedef struct packed {
		logic              vld;
		logic [FREE_W-1:0] row;
		logic [FREE_W-1:0] col;
		logic              rhs;
		logic              ovf;
		logic              last;
	} tag_t;

	// saturated Q16.16 product
	typedef struct packed {
		logic                    sat;
		logic signed [VAL_W-1:0] val;
	} qres_t;

	// Shift a full product right by 16 (floor) and clip to 32 bits.
	function automatic qres_t qsat(input logic signed [PROD_W-1:0] p);
		qres_t r;
		r.sat = (p[PROD_W-1:47] != {(PROD_W-47){p[PROD_W-1]}});
		if (r.sat) begin
			r.val = p[PROD_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			r.val = p[47:16];
		end
		return r;
	endfunction

endpackage

// File: hdl/sdce_qmul.sv
// Registered Q16.16 multiplier with saturation and result output stage.
module sdce_qmul
	import sdce_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [VAL_W-1:0] a,
	input  logic signed [VAL_W-1:0] b,
	input  tag_t                    tag,
	output qres_t                   q,
	output tag_t                    res_tag,
	output logic signed [VAL_W-1:0] res_val
);

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] p_s1;
	tag_t                     tag_s1;
	tag_t                     tag_s2;
	logic signed [VAL_W-1:0]  val_s2;

	assign prod = a * b;

	// register the exact product and its tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s1   <= '0;
			tag_s1 <= '0;
		end else begin
			p_s1   <= prod;
			tag_s1 <= tag;
		end
	end

	// saturate the held product
	assign q = qsat(p_s1);

	// drive the result item for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			val_s2 <= '0;
		end else begin
			tag_s2 <= '{vld: tag_s1.vld, row: tag_s1.row, col: tag_s1.col, rhs: tag_s1.rhs,
				ovf: tag_s1.ovf | q.sat, last: tag_s1.last};
			val_s2 <= q.val;
		end
	end

	assign res_tag = tag_s2;
	assign res_val = val_s2;

endmodule

// File: hdl/sparse_dof_condensation_expander_core.sv
// Top level of the sparse DOF condensation expander: table memories and sequencer.
//
// Loads of an offset or an entry leave the block idle. A right-hand-side item
// yields rn results and a matrix nonzero rn*cn results, where rn and cn are the
// row and column run lengths (at most MAX_EXPAND each); an item whose run is
// empty or out of range ends with no result. Each table memory has a single read
// port: offsets are fetched one per cycle, the column run is buffered one entry
// per cycle, and each row entry costs a read and a scaling multiply before its
// row of products streams out at one item per cycle. Results are registered in
// the product register and the output stage of the multiplier, each shown for
// exactly one cycle under result_valid; the receiver cannot stall.
module sparse_dof_condensation_expander_core
	import sdce_pkg::*;
#(
	parameter int MAX_DOFS    = 4096,
	parameter int MAX_ENTRIES = 8192,
	parameter int MAX_EXPAND  = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              req_type,
	input  logic [DOF_W-1:0]        dof_index,
	input  logic [COL_W-1:0]        col_index,
	input  logic [POS_W-1:0]        entry_pos,
	input  logic [FREE_W-1:0]       free_index,
	input  logic signed [VAL_W-1:0] weight,
	input  logic signed [VAL_W-1:0] value,
	output logic                    result_valid,
	output logic [FREE_W-1:0]       out_row,
	output logic [FREE_W-1:0]       out_col,
	output logic signed [VAL_W-1:0] out_value,
	output logic                    is_rhs,
	output logic                    overflow,
	output logic                    last
);

	localparam int DW = $clog2(MAX_DOFS + 1);
	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int GW = ((DW > DOF_W) ? DW : DOF_W) + 1;
	localparam int CW = ((EW > POS_W) ? EW : POS_W) + 1;
	localparam int NW = $clog2(MAX_EXPAND + 1);
	localparam int JW = (MAX_EXPAND > 1) ? $clog2(MAX_EXPAND) : 1;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_RB   = 11'b000_0000_0010,
		S_RE   = 11'b000_0000_0100,
		S_CB   = 11'b000_0000_1000,
		S_CE   = 11'b000_0001_0000,
		S_CR   = 11'b000_0010_0000,
		S_CL   = 11'b000_0100_0000,
		S_RRD  = 11'b000_1000_0000,
		S_RM1  = 11'b001_0000_0000,
		S_RM2  = 11'b010_0000_0000,
		S_CM   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// accepted item
	req_t                    typ_q;
	logic [DOF_W-1:0]        g_q;
	logic [COL_W-1:0]        c_q;
	logic signed [VAL_W-1:0] val_q;

	// table memories
	logic [POS_W-1:0] off_mem [MAX_DOFS+1];
	ent_t             ent_mem [MAX_ENTRIES];
	logic [POS_W-1:0] off_rd_q;
	ent_t             ent_rd_q;

	// run bookkeeping
	logic [POS_W-1:0]        rb_q;
	logic [EW-1:0]           rs_q;
	logic [EW-1:0]           cs_q;
	logic [NW-1:0]           rn_q;
	logic [NW-1:0]           cn_q;
	logic                    trunc_q;
	logic [NW-1:0]           i_q;
	logic [NW-1:0]           j_q;
	ent_t                    cbuf_q [MAX_EXPAND];
	logic signed [VAL_W-1:0] rv_q;
	logic                    s1_q;
	logic [FREE_W-1:0]       rfree_q;

	logic          accept;
	logic [GW-1:0] ld_dof;
	logic [GW-1:0] g_ext;
	logic [GW-1:0] g_nxt;
	logic [GW-1:0] c_ext;
	logic [GW-1:0] c_nxt;
	logic          g_ok;
	logic          c_ok;
	logic          off_we;
	logic          ent_we;
	logic [CW-1:0] ld_pos;
	logic          off_re;
	logic [DW-1:0] off_raddr;
	logic          ent_re;
	logic [EW-1:0] ent_raddr;
	logic [CW-1:0] b_ext;
	logic [CW-1:0] e_ext;
	logic [CW-1:0] e_cl;
	logic [CW-1:0] run_len;
	logic          run_empty;
	logic          run_trunc;
	logic [NW-1:0] run_n;
	logic [EW-1:0] run_start;
	logic          row_last;
	logic          col_last;
	logic [JW-1:0] jx;

	logic signed [VAL_W-1:0] mul_a;
	logic signed [VAL_W-1:0] mul_b;
	tag_t                    tag;
	qres_t                   q;
	tag_t                    res_tag;
	logic signed [VAL_W-1:0] res_val;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// range checks of the load slots and the requested DOFs
	assign ld_dof = GW'(dof_index);
	assign ld_pos = CW'(entry_pos);
	assign off_we = accept && (req_type == REQ_LOAD_OFFSET) && (ld_dof <= GW'(MAX_DOFS));
	assign ent_we = accept && (req_type == REQ_LOAD_ENTRY) && (ld_pos < CW'(MAX_ENTRIES));

	assign g_ext = GW'(g_q);
	assign g_nxt = g_ext + GW'(1);
	assign c_ext = GW'(c_q);
	assign c_nxt = c_ext + GW'(1);
	assign g_ok  = g_ext < GW'(MAX_DOFS);
	assign c_ok  = c_ext < GW'(MAX_DOFS);

	// run from begin offset in rb_q and end offset just read
	assign b_ext     = CW'(rb_q);
	assign e_ext     = CW'(off_rd_q);
	assign e_cl      = (e_ext > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : e_ext;
	assign run_empty = (e_cl <= b_ext);
	assign run_len   = e_cl - b_ext;
	assign run_trunc = !run_empty && (run_len > CW'(MAX_EXPAND));
	assign run_n     = run_trunc ? NW'(MAX_EXPAND) : run_len[NW-1:0];
	assign run_start = b_ext[EW-1:0];

	assign row_last = (i_q == rn_q - NW'(1));
	assign col_last = (j_q == cn_q - NW'(1));
	assign jx       = j_q[JW-1:0];

	// select the offset and entry read addresses
	always_comb begin
		off_re    = 1'b0;
		off_raddr = g_ext[DW-1:0];
		ent_re    = 1'b0;
		ent_raddr = rs_q + EW'(i_q);
		case (state_q)
			S_RB: begin
				off_re    = g_ok;
				off_raddr = g_ext[DW-1:0];
			end
			S_RE: begin
				off_re    = 1'b1;
				off_raddr = g_nxt[DW-1:0];
			end
			S_CB: begin
				off_re    = c_ok;
				off_raddr = c_ext[DW-1:0];
			end
			S_CE: begin
				off_re    = 1'b1;
				off_raddr = c_nxt[DW-1:0];
			end
			S_CR: begin
				ent_re    = !run_empty;
				ent_raddr = run_start;
			end
			S_CL: begin
				ent_re    = !col_last;
				ent_raddr = cs_q + EW'(j_q) + EW'(1);
			end
			S_RRD: begin
				ent_re    = 1'b1;
				ent_raddr = rs_q + EW'(i_q);
			end
			default: begin
				off_re = 1'b0;
				ent_re = 1'b0;
			end
		endcase
	end

	// offset table: one write on a load, one registered read
	always_ff @(posedge clk) begin
		if (off_we) begin
			off_mem[ld_dof[DW-1:0]] <= entry_pos;
		end
		if (off_re) begin
			off_rd_q <= off_mem[off_raddr];
		end
	end

	// expansion entry table: one write on a load, one registered read
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ld_pos[EW-1:0]] <= '{free: free_index, w: weight};
		end
		if (ent_re) begin
			ent_rd_q <= ent_mem[ent_raddr];
		end
	end

	// multiplier operands and the tag of the product issued this cycle
	always_comb begin
		mul_a    = val_q;
		mul_b    = ent_rd_q.w;
		tag.vld  = 1'b0;
		tag.row  = ent_rd_q.free;
		tag.col  = '0;
		tag.rhs  = 1'b1;
		tag.ovf  = trunc_q;
		tag.last = row_last;
		if (state_q == S_CM) begin
			mul_a    = rv_q;
			mul_b    = cbuf_q[jx].w;
			tag.vld  = 1'b1;
			tag.row  = rfree_q;
			tag.col  = cbuf_q[jx].free;
			tag.rhs  = 1'b0;
			tag.ovf  = trunc_q | s1_q;
			tag.last = row_last && col_last;
		end else if (state_q == S_RM1) begin
			tag.vld = (typ_q == REQ_RHS);
		end
	end

	sdce_qmul u_qmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.a       (mul_a),
		.b       (mul_b),
		.tag     (tag),
		.q       (q),
		.res_tag (res_tag),
		.res_val (res_val)
	);

	// sequencer: fetch runs, buffer the column run, walk rows then columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			trunc_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (req_type == REQ_NONZERO || req_type == REQ_RHS)) begin
						trunc_q <= 1'b0;
						state_q <= S_RB;
					end
				end
				S_RB: begin
					state_q <= g_ok ? S_RE : S_IDLE;
				end
				S_RE: begin
					state_q <= S_CB;
				end
				S_CB: begin
					trunc_q <= run_trunc;
					i_q     <= '0;
					if (run_empty) begin
						state_q <= S_IDLE;
					end else if (typ_q == REQ_RHS) begin
						state_q <= S_RRD;
					end else begin
						state_q <= c_ok ? S_CE : S_IDLE;
					end
				end
				S_CE: begin
					state_q <= S_CR;
				end
				S_CR: begin
					trunc_q <= trunc_q | run_trunc;
					j_q     <= '0;
					state_q <= run_empty ? S_IDLE : S_CL;
				end
				S_CL: begin
					if (col_last) begin
						state_q <= S_RRD;
					end else begin
						j_q <= j_q + NW'(1);
					end
				end
				S_RRD: begin
					state_q <= S_RM1;
				end
				S_RM1: begin
					if (typ_q == REQ_RHS) begin
						if (row_last) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + NW'(1);
							state_q <= S_RRD;
						end
					end else begin
						state_q <= S_RM2;
					end
				end
				S_RM2: begin
					j_q     <= '0;
					state_q <= S_CM;
				end
				S_CM: begin
					if (col_last) begin
						if (row_last) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + NW'(1);
							state_q <= S_RRD;
						end
					end else begin
						j_q <= j_q + NW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold item fields, run bounds and the scaled row value
	always_ff @(posedge clk) begin
		if (accept) begin
			typ_q <= req_t'(req_type);
			g_q   <= dof_index;
			c_q   <= col_index;
			val_q <= value;
		end
		if (state_q == S_RE || state_q == S_CE) begin
			rb_q <= off_rd_q;
		end
		if (state_q == S_CB) begin
			rs_q <= run_start;
			rn_q <= run_n;
		end
		if (state_q == S_CR) begin
			cs_q <= run_start;
			cn_q <= run_n;
		end
		if (state_q == S_CL) begin
			cbuf_q[jx] <= ent_rd_q;
		end
		if (state_q == S_RM1) begin
			rfree_q <= ent_rd_q.free;
		end
		if (state_q == S_RM2) begin
			rv_q <= q.val;
			s1_q <= q.sat;
		end
	end

	assign result_valid = res_tag.vld;
	assign out_row      = res_tag.row;
	assign out_col      = res_tag.col;
	assign out_value    = res_val;
	assign is_rhs       = res_tag.rhs;
	assign overflow     = res_tag.ovf;
	assign last         = res_tag.last;

	// a result only follows a product issued while busy
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy, 2))
		else $error("result without a preceding busy cycle");

	// the final result of an item is never directly followed by another
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("result directly after a final result");

	// rhs contributions carry column zero
	a_rhs_col: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_rhs |-> out_col == '0)
		else $error("rhs result with nonzero column");

	// column walk stays inside the buffered run
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CM || state_q == S_CL) |-> j_q < cn_q)
		else $error("column index past the run");

	// row walk stays inside the row run
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RRD) |-> i_q < rn_q)
		else $error("row index past the run");

endmodule

// File: dv/sdce_checker.sv
// Checker of the DOF expander: mirrors the expansion table, predicts contributions, compares.
module sdce_checker
	import sdce_pkg::*;
#(
	parameter int MAX_DOFS    = 4096,
	parameter int MAX_ENTRIES = 8192,
	parameter int MAX_EXPAND  = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [1:0]              req_type,
	input  logic [DOF_W-1:0]        dof_index,
	input  logic [COL_W-1:0]        col_index,
	input  logic [POS_W-1:0]        entry_pos,
	input  logic [FREE_W-1:0]       free_index,
	input  logic signed [VAL_W-1:0] weight,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    result_valid,
	input  logic [FREE_W-1:0]       out_row,
	input  logic [FREE_W-1:0]       out_col,
	input  logic signed [VAL_W-1:0] out_value,
	input  logic                    is_rhs,
	input  logic                    overflow,
	input  logic                    last,
	output int                      mismatches,
	output int                      pending
);

	// one weighted contribution as it leaves the block
	typedef struct packed {
		logic [FREE_W-1:0]       row;
		logic [FREE_W-1:0]       col;
		logic signed [VAL_W-1:0] val;
		logic                    rhs;
		logic                    ovf;
		logic                    last;
	} contrib_t;

	localparam logic signed [PROD_W-1:0] Q_HI = 64'sd2147483647;
	localparam logic signed [PROD_W-1:0] Q_LO = -64'sd2147483648;
	localparam int OWED_DEPTH = 256;

	// shadow copy of the compressed-row expansion table
	logic [POS_W-1:0]        slot_of   [0:MAX_DOFS];
	logic [FREE_W-1:0]       ent_free  [0:MAX_ENTRIES-1];
	logic signed [VAL_W-1:0] ent_w     [0:MAX_ENTRIES-1];

	// predicted contributions in arrival order, kept as a ring
	contrib_t   owed_contribs [0:OWED_DEPTH-1];
	logic [7:0] owed_wr = '0;
	logic [7:0] owed_rd = '0;
	int         owed_n = 0;
	contrib_t   seen;
	contrib_t   want;
	int         fails = 0;
	int         owed_cnt = 0;

	assign mismatches = fails;
	assign pending    = owed_cnt;

	task automatic note_mismatch(input string what);
		$display("%0t ERROR %s", $time, what);
		fails++;
	endtask

	function automatic string show(input contrib_t c);
		return $sformatf("row %0d col %0d value %0d rhs %0b ovf %0b last %0b",
			c.row, c.col, c.val, c.rhs, c.ovf, c.last);
	endfunction

	// Append one predicted contribution behind those still owed.
	task automatic owe(input contrib_t x);
		if (owed_n >= OWED_DEPTH) begin
			note_mismatch("too many contributions owed");
		end else begin
			owed_contribs[owed_wr] = x;
			owed_wr = owed_wr + 8'd1;
			owed_n++;
		end
	endtask

	// Q16.16 product: exact, floor shift by 16, clip to 32 bits
	function automatic logic signed [VAL_W-1:0] q_mul(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b, inout bit sat);
		logic signed [PROD_W-1:0] xa;
		logic signed [PROD_W-1:0] xb;
		logic signed [PROD_W-1:0] p;
		xa = a;
		xb = b;
		p = (xa * xb) >>> 16;
		if (p > Q_HI) begin
			sat = 1'b1;
			return 32'sh7fff_ffff;
		end
		if (p < Q_LO) begin
			sat = 1'b1;
			return 32'sh8000_0000;
		end
		return p[VAL_W-1:0];
	endfunction

	// Locate the expansion run of one DOF, cut to MAX_EXPAND entries.
	function automatic int unsigned run_of(input int unsigned g, output int unsigned first,
		inout bit cut);
		int unsigned b;
		int unsigned e;
		first = 0;
		if (g >= MAX_DOFS) return 0;
		b = 32'(slot_of[g]);
		e = 32'(slot_of[g+1]);
		if (e > MAX_ENTRIES) e = MAX_ENTRIES;
		if (e <= b) return 0;
		first = b;
		if (e - b > MAX_EXPAND) begin
			cut = 1'b1;
			return MAX_EXPAND;
		end
		return e - b;
	endfunction

	// Apply one accepted item: update the table or queue its contributions.
	task automatic condense_expand(input req_t kind, input logic [DOF_W-1:0] g,
		input logic [COL_W-1:0] c, input logic [POS_W-1:0] p, input logic [FREE_W-1:0] f,
		input logic signed [VAL_W-1:0] w, input logic signed [VAL_W-1:0] v);
		int unsigned rs, cs, rn, cn, i, j, n_out;
		bit cut, s1, s2;
		logic signed [VAL_W-1:0] rv, pv;
		contrib_t x;
		cut = 1'b0;
		n_out = 0;
		case (kind)
			REQ_LOAD_OFFSET: begin
				if (g <= MAX_DOFS) slot_of[g] = p;
			end
			REQ_LOAD_ENTRY: begin
				if (p < MAX_ENTRIES) begin
					ent_free[p] = f;
					ent_w[p] = w;
				end
			end
			REQ_NONZERO: begin
				rn = run_of(32'(g), rs, cut);
				cn = run_of(32'(c), cs, cut);
				for (i = 0; i < rn; i++) begin
					s1 = 1'b0;
					rv = q_mul(v, ent_w[rs+i], s1);
					for (j = 0; j < cn; j++) begin
						s2 = s1;
						pv = q_mul(rv, ent_w[cs+j], s2);
						x = '{ent_free[rs+i], ent_free[cs+j], pv, 1'b0, cut | s2, 1'b0};
						owe(x);
						n_out++;
					end
				end
			end
			default: begin
				rn = run_of(32'(g), rs, cut);
				for (i = 0; i < rn; i++) begin
					s1 = 1'b0;
					pv = q_mul(v, ent_w[rs+i], s1);
					x = '{ent_free[rs+i], '0, pv, 1'b1, cut | s1, 1'b0};
					owe(x);
					n_out++;
				end
			end
		endcase
		// flag the final contribution of this item
		if (n_out > 0) owed_contribs[owed_wr - 8'd1].last = 1'b1;
	endtask

	// Compare results first, then predict the item taken at this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_wr = '0;
			owed_rd = '0;
			owed_n = 0;
			owed_cnt <= 0;
		end else begin
			if (result_valid) begin
				seen = '{out_row, out_col, out_value, is_rhs, overflow, last};
				if (owed_n == 0) begin
					note_mismatch({"unexpected result: ", show(seen)});
				end else begin
					want = owed_contribs[owed_rd];
					owed_rd = owed_rd + 8'd1;
					owed_n--;
					if (seen !== want)
						note_mismatch({"got ", show(seen), " expected ", show(want)});
				end
			end
			if (start && !busy)
				condense_expand(req_t'(req_type), dof_index, col_index, entry_pos,
					free_index, weight, value);
			owed_cnt <= owed_n;
		end
	end

endmodule

// File: dv/tb.sv
// Testbench top of the DOF expander: clock, reset, item stimulus and verdict.
module tb;
	import sdce_pkg::*;

	localparam int DOFS    = 4096;
	localparam int ENTRIES = 8192;
	localparam int EXPAND  = 8;
	localparam int LIMIT   = 400000;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              req_type;
	logic [DOF_W-1:0]        dof_index;
	logic [COL_W-1:0]        col_index;
	logic [POS_W-1:0]        entry_pos;
	logic [FREE_W-1:0]       free_index;
	logic signed [VAL_W-1:0] weight;
	logic signed [VAL_W-1:0] value;
	logic                    result_valid;
	logic [FREE_W-1:0]       out_row;
	logic [FREE_W-1:0]       out_col;
	logic signed [VAL_W-1:0] out_value;
	logic                    is_rhs;
	logic                    overflow;
	logic                    last;
	int                      mismatches;
	int                      pending;

	// what has been written, so that no unwritten slot is ever read
	bit                      off_set [0:DOFS];
	int unsigned             off_at  [0:DOFS];
	bit                      ent_set [0:ENTRIES-1];
	int unsigned             items = 0;
	int unsigned             cycles = 0;
	bit                      burst = 1'b0;
	bit                      drained_once = 1'b0;

	sparse_dof_condensation_expander_core #(
		.MAX_DOFS(DOFS),
		.MAX_ENTRIES(ENTRIES),
		.MAX_EXPAND(EXPAND)
	) i_dut (.*);

	sdce_checker #(
		.MAX_DOFS(DOFS),
		.MAX_ENTRIES(ENTRIES),
		.MAX_EXPAND(EXPAND)
	) i_check (.*);

	always #5 clk = ~clk;

	// give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Q16.16 operand: extremes, full range or a few units around zero
	function automatic logic signed [VAL_W-1:0] rnd_q();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2, 3, 4: return $urandom;
			default: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
		endcase
	endfunction

	// Tell whether every offset and entry of a DOF's run has been written.
	function automatic bit run_readable(input int unsigned g);
		int unsigned b, e, n, k;
		if (g >= DOFS) return 1'b1;
		if (!off_set[g] || !off_set[g+1]) return 1'b0;
		b = off_at[g];
		e = off_at[g+1];
		if (e > ENTRIES) e = ENTRIES;
		if (e <= b) return 1'b1;
		n = (e - b > EXPAND) ? EXPAND : e - b;
		for (k = 0; k < n; k++)
			if (!ent_set[b+k]) return 1'b0;
		return 1'b1;
	endfunction

	// Pick a DOF near either end of the table whose run is safe to read, else one past the table.
	function automatic int unsigned pick_dof();
		int unsigned g, t;
		for (t = 0; t < 12; t++) begin
			g = ($urandom_range(0, 4) == 0) ? $urandom_range(4090, 4095) : $urandom_range(0, 19);
			if (run_readable(g)) return g;
		end
		return $urandom_range(DOFS, 8191);
	endfunction

	// Idle the sender for a random gap, mostly short.
	task automatic idle_after();
		int unsigned r, n;
		if (burst) return;
		r = $urandom_range(0, 99);
		if (r < 40) n = 0;
		else if (r < 85) n = $urandom_range(1, 3);
		else if (r < 95) n = $urandom_range(4, 12);
		else n = $urandom_range(20, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Present one item and hold it until the block takes it.
	task automatic issue(input req_t kind, input int unsigned g, input int unsigned c,
		input int unsigned p, input int unsigned f, input logic signed [VAL_W-1:0] w,
		input logic signed [VAL_W-1:0] v);
		items++;
		start      <= 1'b1;
		req_type   <= kind;
		dof_index  <= DOF_W'(g);
		col_index  <= COL_W'(c);
		entry_pos  <= POS_W'(p);
		free_index <= FREE_W'(f);
		weight     <= w;
		value      <= v;
		do @(posedge clk); while (busy);
		idle_after();
	endtask

	task automatic put_offset(input int unsigned slot, input int unsigned pos);
		if (slot <= DOFS) begin
			off_set[slot] = 1'b1;
			off_at[slot] = pos;
		end
		issue(REQ_LOAD_OFFSET, slot, $urandom_range(0, 4095), pos, $urandom_range(0, 4095),
			$urandom, $urandom);
	endtask

	task automatic put_entry(input int unsigned pos, input int unsigned f,
		input logic signed [VAL_W-1:0] w);
		if (pos < ENTRIES) begin
			ent_set[pos] = 1'b1;
		end
		issue(REQ_LOAD_ENTRY, $urandom_range(0, 8191), $urandom_range(0, 4095), pos, f, w,
			$urandom);
	endtask

	task automatic ask_rhs(input int unsigned g, input logic signed [VAL_W-1:0] v);
		issue(REQ_RHS, g, $urandom_range(0, 4095), $urandom_range(0, 16383),
			$urandom_range(0, 4095), $urandom, v);
	endtask

	task automatic ask_nonzero(input int unsigned r, input int unsigned c,
		input logic signed [VAL_W-1:0] v);
		issue(REQ_NONZERO, r, c, $urandom_range(0, 16383), $urandom_range(0, 4095), $urandom, v);
	endtask

	// Hold the sender until every owed contribution has come out.
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Rewrite a few consecutive offsets with fresh runs and fill their entries.
	task automatic rebuild_runs();
		int unsigned g0, k, cur, lo, hi, j, p;
		if ($urandom_range(0, 3) == 0) begin
			g0 = $urandom_range(4090, 4095);
			cur = $urandom_range(8176, 8191);
		end else begin
			g0 = $urandom_range(0, 15);
			cur = $urandom_range(0, 30);
		end
		k = $urandom_range(1, 3);
		if (g0 + k > DOFS) k = DOFS - g0;
		lo = cur;
		hi = cur;
		for (j = 0; j <= k; j++) begin
			put_offset(g0 + j, cur);
			if (cur < lo) lo = cur;
			if (cur > hi) hi = cur;
			// mostly growing runs, now and then a reversed one
			if ($urandom_range(0, 7) == 0) cur = (cur > 3) ? cur - $urandom_range(1, 3) : cur;
			else cur = cur + $urandom_range(0, 10);
		end
		for (p = lo; p < hi && p < ENTRIES; p++)
			put_entry(p, $urandom_range(0, 4095), rnd_q());
	endtask

	// One matrix or rhs request on DOFs whose runs are safe to read.
	task automatic random_op();
		int unsigned r, c;
		r = pick_dof();
		if ($urandom_range(0, 9) < 6) begin
			c = pick_dof();
			if ($urandom_range(0, 19) == 0) r = $urandom_range(DOFS, 8191);
			if (c < DOFS) ask_nonzero(r, c, rnd_q());
			else ask_rhs(r, rnd_q());
		end else begin
			ask_rhs(r, rnd_q());
		end
	endtask

	// Items outside the table that the block must ignore or answer with nothing.
	task automatic noise_item();
		case ($urandom_range(0, 2))
			0: put_offset($urandom_range(DOFS + 1, 8191), $urandom_range(0, 16383));
			1: put_entry($urandom_range(ENTRIES, 16383), $urandom_range(0, 4095), $urandom);
			default: ask_rhs($urandom_range(DOFS, 8191), rnd_q());
		endcase
	endtask

	initial begin
		int unsigned k;
		arst_n     = 1'b0;
		start      = 1'b0;
		req_type   = REQ_LOAD_OFFSET;
		dof_index  = '0;
		col_index  = '0;
		entry_pos  = '0;
		free_index = '0;
		weight     = '0;
		value      = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table: a short run, a long run, an empty, a reversed and a clamped one
		for (k = 0; k < 12; k++)
			put_entry(k, (k == 0) ? 0 : (k == 1) ? 4095 : $urandom_range(0, 4095),
				(k == 0) ? 32'sh7fff_ffff : (k == 1) ? 32'sh8000_0000 :
				(k == 2) ? 32'sh0001_0000 : rnd_q());
		put_entry(8190, $urandom_range(0, 4095), rnd_q());
		put_entry(8191, $urandom_range(0, 4095), rnd_q());
		put_entry(16383, 4095, 32'sh7fff_ffff);
		put_offset(0, 0);
		put_offset(1, 3);
		put_offset(2, 12);
		put_offset(3, 12);
		put_offset(4, 5);
		put_offset(4095, 8190);
		put_offset(4096, 16383);
		put_offset(4097, 0);
		put_offset(8191, 0);

		// rhs: saturation, long run, empty, reversed, out of range, clamped
		ask_rhs(0, 32'sh7fff_ffff);
		ask_rhs(1, 32'sh8000_0000);
		ask_rhs(2, rnd_q());
		ask_rhs(3, rnd_q());
		ask_rhs(4096, rnd_q());
		ask_rhs(8191, rnd_q());
		ask_rhs(4095, rnd_q());

		// nonzeros: saturation, 8 by 8 cut runs, empty sides, out of range row
		ask_nonzero(0, 0, 32'sh8000_0000);
		ask_nonzero(1, 1, rnd_q());
		ask_nonzero(0, 2, rnd_q());
		ask_nonzero(2, 0, rnd_q());
		ask_nonzero(3, 0, rnd_q());
		ask_nonzero(4096, 0, rnd_q());
		ask_nonzero(8191, 4095, rnd_q());
		ask_nonzero(4095, 4095, rnd_q());
		ask_nonzero(0, 4095, rnd_q());
		ask_nonzero(1, 0, 32'sh0000_0000);
		wait_drained();

		// random rounds: refresh some runs, then query them
		while (items < 100) begin
			burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0) rebuild_runs();
			repeat ($urandom_range(2, 6)) random_op();
			if ($urandom_range(0, 5) == 0) noise_item();
			if (!drained_once && items >= 55) begin
				wait_drained();
				drained_once = 1'b1;
			end
		end

		// drain, then allow the pipeline tail to show any stray result
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
